/* rtl/gmt_pkg.sv */
// Shared types, widths and codes of the gossip membership table.
package gmt_pkg;

   localparam int IdW = 31;
   localparam int PortW = 16;
   localparam int HbW = 32;
   localparam int ToW = 16;
   localparam int OpW = 2;
   localparam int KindW = 3;
   localparam int MaxResults = 32;
   localparam int NresW = $clog2(MaxResults + 1);
   localparam int AddrW = 4;

   localparam logic [OpW-1:0] OP_MERGE = 2'd0;
   localparam logic [OpW-1:0] OP_TICK = 2'd1;
   localparam logic [OpW-1:0] OP_LIST = 2'd2;

   localparam logic [KindW-1:0] K_NONE = 3'd0;
   localparam logic [KindW-1:0] K_ADDED = 3'd1;
   localparam logic [KindW-1:0] K_REPLACED = 3'd2;
   localparam logic [KindW-1:0] K_REFRESHED = 3'd3;
   localparam logic [KindW-1:0] K_REMOVED = 3'd4;
   localparam logic [KindW-1:0] K_PING = 3'd5;
   localparam logic [KindW-1:0] K_LIVE = 3'd6;
   localparam logic [KindW-1:0] K_ALONE = 3'd7;

   localparam logic [1:0] REG_SELF_ID = 2'd0;
   localparam logic [1:0] REG_SELF_PORT = 2'd1;
   localparam logic [1:0] REG_FAIL_TO = 2'd2;
   localparam logic [1:0] REG_REMOVE_TO = 2'd3;

   typedef struct packed {
      logic [IdW-1:0]   self_id;
      logic [PortW-1:0] self_port;
      logic [ToW-1:0]   fail_timeout;
      logic [ToW-1:0]   remove_timeout;
   } cfg_type;

   typedef struct packed {
      logic [OpW-1:0]   operation;
      logic             is_self;
      logic [IdW-1:0]   member_id;
      logic [PortW-1:0] member_port;
      logic [HbW-1:0]   member_heartbeat;
   } item_type;

   typedef struct packed {
      logic [IdW-1:0]   id;
      logic [PortW-1:0] port;
      logic [HbW-1:0]   heartbeat;
      logic [HbW-1:0]   stamp;
   } entry_type;

   typedef struct packed {
      logic [KindW-1:0] kind;
      logic [IdW-1:0]   id;
      logic [PortW-1:0] port;
      logic [HbW-1:0]   heartbeat;
   } result_type;

endpackage

/* rtl/gmt_req_if.sv */
// Request channel interface: valid/ready and the gossiped item fields.
interface gmt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [30:0] member_id;
   logic [15:0] member_port;
   logic [31:0] member_heartbeat;

   modport source (output valid, operation, member_id, member_port, member_heartbeat,
                   input ready);
   modport sink (input valid, operation, member_id, member_port, member_heartbeat,
                 output ready);
endinterface

/* rtl/gmt_rsp_if.sv */
// Response channel interface: valid/ready and the result fields.
interface gmt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  result_kind;
   logic [30:0] entry_id;
   logic [15:0] entry_port;
   logic [31:0] entry_heartbeat;
   logic        last;

   modport source (output valid, result_kind, entry_id, entry_port, entry_heartbeat, last,
                   input ready);
   modport sink (input valid, result_kind, entry_id, entry_port, entry_heartbeat, last,
                 output ready);
endinterface

/* rtl/gmt_csr.sv */
// Configuration registers behind the APB-style port.
module gmt_csr
   import gmt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [AddrW-1:0] paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output cfg_type          cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign wr_en = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[3:2])
            REG_SELF_ID:   cfg_in.self_id = pwdata[IdW-1:0];
            REG_SELF_PORT: cfg_in.self_port = pwdata[PortW-1:0];
            REG_FAIL_TO:   cfg_in.fail_timeout = pwdata[ToW-1:0];
            REG_REMOVE_TO: cfg_in.remove_timeout = pwdata[ToW-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.self_id <= 31'd1;
         cfg_ff.self_port <= 16'd0;
         cfg_ff.fail_timeout <= 16'd5;
         cfg_ff.remove_timeout <= 16'd20;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_SELF_ID:   prdata = {1'b0, cfg_ff.self_id};
         REG_SELF_PORT: prdata = {16'd0, cfg_ff.self_port};
         REG_FAIL_TO:   prdata = {16'd0, cfg_ff.fail_timeout};
         REG_REMOVE_TO: prdata = {16'd0, cfg_ff.remove_timeout};
         default:       prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/gmt_front.sv */
// Front end: accepts requests, flags own-id merges and queues them for the engine.
module gmt_front
   import gmt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   gmt_req_if.sink        req_ch,
   input  logic [IdW-1:0] self_id,
   output logic           item_valid,
   output item_type       item,
   input  logic           item_pop
);

   item_type   slot_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   item_type   cls;

   assign req_ch.ready = (cnt_ff != 2'd2);
   assign push = req_ch.valid && req_ch.ready;
   assign item_valid = (cnt_ff != 2'd0);
   assign item = slot_ff[rptr_ff];

   always_comb begin
      cls.operation = req_ch.operation;
      cls.is_self = (req_ch.member_id == self_id);
      cls.member_id = req_ch.member_id;
      cls.member_port = req_ch.member_port;
      cls.member_heartbeat = req_ch.member_heartbeat;
   end

   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = item_pop ? ~rptr_ff : rptr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= cls;
      end
   end

endmodule

/* rtl/gmt_engine.sv */
// Back end: table memory and the sequencer that merges, ticks and lists.
module gmt_engine
   import gmt_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
)
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     item_valid,
   input  item_type item,
   output logic     item_pop,
   gmt_rsp_if.source rsp_ch
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int DivCntW = $clog2(HbW + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RD = 4'd1;
   localparam logic [3:0] S_USE = 4'd2;
   localparam logic [3:0] S_MERGE_END = 4'd3;
   localparam logic [3:0] S_TICK_END = 4'd4;
   localparam logic [3:0] S_DIV = 4'd5;
   localparam logic [3:0] S_PRD = 4'd6;
   localparam logic [3:0] S_PUSE = 4'd7;
   localparam logic [3:0] S_FLUSH = 4'd8;

   entry_type  mem_ff [TABLE_DEPTH];
   entry_type  rd_ff;

   logic [3:0]         state_ff, state_in;
   item_type           cur_ff, cur_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      wr_ff, wr_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      offset_ff, offset_in;
   logic [HbW-1:0]     lhb_ff, lhb_in;
   logic [NresW-1:0]   nres_ff, nres_in;
   logic [CW-1:0]      old_pos_ff, old_pos_in;
   logic [HbW-1:0]     old_stamp_ff, old_stamp_in;
   entry_type          old_entry_ff, old_entry_in;
   logic               hold_v_ff, hold_v_in;
   result_type         hold_ff, hold_in;
   logic [CW-1:0]      rem_ff, rem_in;
   logic [HbW-1:0]     quo_ff, quo_in;
   logic [DivCntW-1:0] dcnt_ff, dcnt_in;
   logic               out_v_ff, out_v_in;
   result_type         out_ff, out_in;
   logic               out_last_ff, out_last_in;

   logic       out_free, go, want_emit;
   result_type emit_res;
   logic       mem_we;
   logic [IW-1:0] mem_wa;
   entry_type  mem_wd;
   logic [HbW-1:0] age;
   logic [CW:0]    rem_sh;
   logic [CW-1:0]  span;
   entry_type  new_entry;
   result_type self_res;

   assign out_free = !out_v_ff || rsp_ch.ready;
   assign go = !(want_emit && hold_v_ff && !out_free);
   assign age = lhb_ff - rd_ff.stamp;
   assign span = count_ff - CW'(1);
   assign rem_sh = {rem_ff, quo_ff[HbW-1]};

   always_comb begin
      new_entry.id = cur_ff.member_id;
      new_entry.port = cur_ff.member_port;
      new_entry.heartbeat = cur_ff.member_heartbeat;
      new_entry.stamp = lhb_ff;
      self_res.kind = K_LIVE;
      self_res.id = cfg.self_id;
      self_res.port = cfg.self_port;
      self_res.heartbeat = lhb_ff;
   end

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      idx_in = idx_ff;
      wr_in = wr_ff;
      count_in = count_ff;
      offset_in = offset_ff;
      lhb_in = lhb_ff;
      nres_in = nres_ff;
      old_pos_in = old_pos_ff;
      old_stamp_in = old_stamp_ff;
      old_entry_in = old_entry_ff;
      hold_v_in = hold_v_ff;
      hold_in = hold_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dcnt_in = dcnt_ff;
      item_pop = 1'b0;
      want_emit = 1'b0;
      emit_res = '0;
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = new_entry;
      out_last_in = 1'b0;
      out_in = hold_ff;
      out_v_in = out_v_ff && !rsp_ch.ready;

      case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               cur_in = item;
               nres_in = '0;
               hold_v_in = 1'b0;
               idx_in = CW'(1);
               wr_in = CW'(1);
               old_pos_in = CW'(1);
               old_stamp_in = lhb_ff;
               case (item.operation)
                  OP_MERGE: begin
                     if (item.is_self) begin
                        hold_v_in = 1'b1;
                        hold_in.kind = K_NONE;
                        hold_in.id = item.member_id;
                        hold_in.port = item.member_port;
                        hold_in.heartbeat = item.member_heartbeat;
                        state_in = S_FLUSH;
                     end else begin
                        state_in = (count_ff > CW'(1)) ? S_RD : S_MERGE_END;
                     end
                  end
                  OP_TICK: begin
                     lhb_in = lhb_ff + 32'd1;
                     state_in = (count_ff > CW'(1)) ? S_RD : S_TICK_END;
                  end
                  OP_LIST: begin
                     hold_v_in = 1'b1;
                     hold_in = self_res;
                     nres_in = NresW'(1);
                     state_in = (count_ff > CW'(1)) ? S_RD : S_FLUSH;
                  end
                  default: begin
                     hold_v_in = 1'b1;
                     hold_in = '0;
                     state_in = S_FLUSH;
                  end
               endcase
            end
         end
         S_RD: begin
            state_in = S_USE;
         end
         S_USE: begin
            case (cur_ff.operation)
               OP_MERGE: begin
                  if (rd_ff.id == cur_ff.member_id && rd_ff.port == cur_ff.member_port) begin
                     hold_v_in = 1'b1;
                     if (rd_ff.heartbeat < cur_ff.member_heartbeat) begin
                        mem_we = 1'b1;
                        mem_wa = idx_ff[IW-1:0];
                        hold_in.kind = K_REFRESHED;
                        hold_in.id = rd_ff.id;
                        hold_in.port = rd_ff.port;
                        hold_in.heartbeat = cur_ff.member_heartbeat;
                     end else begin
                        hold_in.kind = K_NONE;
                        hold_in.id = rd_ff.id;
                        hold_in.port = rd_ff.port;
                        hold_in.heartbeat = rd_ff.heartbeat;
                     end
                     state_in = S_FLUSH;
                  end else begin
                     if (idx_ff == CW'(1)) begin
                        old_entry_in = rd_ff;
                     end
                     if (rd_ff.stamp < old_stamp_ff) begin
                        old_stamp_in = rd_ff.stamp;
                        old_pos_in = idx_ff;
                        old_entry_in = rd_ff;
                     end
                     idx_in = idx_ff + CW'(1);
                     state_in = (idx_ff + CW'(1) < count_ff) ? S_RD : S_MERGE_END;
                  end
               end
               OP_TICK: begin
                  if (age >= HbW'(cfg.remove_timeout)) begin
                     want_emit = (nres_ff < NresW'(MaxResults - 1));
                     emit_res.kind = K_REMOVED;
                  end else begin
                     mem_we = 1'b1;
                     mem_wa = wr_ff[IW-1:0];
                     mem_wd = rd_ff;
                  end
                  emit_res.id = rd_ff.id;
                  emit_res.port = rd_ff.port;
                  emit_res.heartbeat = rd_ff.heartbeat;
                  if (go) begin
                     if (!(age >= HbW'(cfg.remove_timeout))) begin
                        wr_in = wr_ff + CW'(1);
                     end
                     idx_in = idx_ff + CW'(1);
                     state_in = (idx_ff + CW'(1) < count_ff) ? S_RD : S_TICK_END;
                  end else begin
                     mem_we = 1'b0;
                  end
               end
               default: begin
                  want_emit = (age <= HbW'(cfg.fail_timeout)) &&
                              (nres_ff < NresW'(MaxResults));
                  emit_res.kind = K_LIVE;
                  emit_res.id = rd_ff.id;
                  emit_res.port = rd_ff.port;
                  emit_res.heartbeat = rd_ff.heartbeat;
                  if (go) begin
                     idx_in = idx_ff + CW'(1);
                     state_in = (idx_ff + CW'(1) < count_ff) ? S_RD : S_FLUSH;
                  end
               end
            endcase
         end
         S_MERGE_END: begin
            mem_we = 1'b1;
            hold_v_in = 1'b1;
            if (count_ff < CW'(TABLE_DEPTH)) begin
               mem_wa = count_ff[IW-1:0];
               count_in = count_ff + CW'(1);
               hold_in.kind = K_ADDED;
               hold_in.id = cur_ff.member_id;
               hold_in.port = cur_ff.member_port;
               hold_in.heartbeat = cur_ff.member_heartbeat;
            end else begin
               mem_wa = old_pos_ff[IW-1:0];
               hold_in.kind = K_REPLACED;
               hold_in.id = old_entry_ff.id;
               hold_in.port = old_entry_ff.port;
               hold_in.heartbeat = old_entry_ff.heartbeat;
            end
            state_in = S_FLUSH;
         end
         S_TICK_END: begin
            want_emit = (wr_ff <= CW'(1));
            emit_res.kind = K_ALONE;
            emit_res.id = cfg.self_id;
            emit_res.port = cfg.self_port;
            emit_res.heartbeat = lhb_ff;
            if (go) begin
               count_in = wr_ff;
               rem_in = '0;
               quo_in = lhb_ff;
               dcnt_in = DivCntW'(HbW);
               state_in = (wr_ff <= CW'(1)) ? S_FLUSH : S_DIV;
            end
         end
         S_DIV: begin
            if ((CW + 1)'(span) <= rem_sh) begin
               rem_in = CW'(rem_sh - (CW + 1)'(span));
            end else begin
               rem_in = rem_sh[CW-1:0];
            end
            quo_in = {quo_ff[HbW-2:0], 1'b0};
            dcnt_in = dcnt_ff - DivCntW'(1);
            if (dcnt_ff == DivCntW'(0)) begin
               rem_in = rem_ff;
               idx_in = rem_ff + CW'(1);
               offset_in = '0;
               state_in = S_PRD;
            end
         end
         S_PRD: begin
            state_in = S_PUSE;
         end
         S_PUSE: begin
            if (offset_ff < count_ff && age > HbW'(cfg.fail_timeout)) begin
               offset_in = offset_ff + CW'(1);
               idx_in = (idx_ff == span) ? CW'(1) : idx_ff + CW'(1);
               state_in = S_PRD;
            end else begin
               want_emit = 1'b1;
               if (age < HbW'(cfg.fail_timeout)) begin
                  emit_res.kind = K_PING;
                  emit_res.id = rd_ff.id;
                  emit_res.port = rd_ff.port;
                  emit_res.heartbeat = rd_ff.heartbeat;
               end
               if (go) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               out_v_in = 1'b1;
               out_in = hold_ff;
               out_last_in = 1'b1;
               hold_v_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (want_emit && go) begin
         if (hold_v_ff) begin
            out_v_in = 1'b1;
            out_in = hold_ff;
            out_last_in = 1'b0;
         end
         hold_v_in = 1'b1;
         hold_in = emit_res;
         nres_in = nres_ff + NresW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= CW'(1);
         lhb_ff <= '0;
         hold_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
         nres_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         lhb_ff <= lhb_in;
         hold_v_ff <= hold_v_in;
         out_v_ff <= out_v_in;
         nres_ff <= nres_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      wr_ff <= wr_in;
      offset_ff <= offset_in;
      old_pos_ff <= old_pos_in;
      old_stamp_ff <= old_stamp_in;
      old_entry_ff <= old_entry_in;
      hold_ff <= hold_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dcnt_ff <= dcnt_in;
      if (out_v_in && (!out_v_ff || rsp_ch.ready)) begin
         out_ff <= out_in;
         out_last_ff <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_wa] <= mem_wd;
      end
      rd_ff <= mem_ff[idx_ff[IW-1:0]];
   end

   assign rsp_ch.valid = out_v_ff;
   assign rsp_ch.result_kind = out_ff.kind;
   assign rsp_ch.entry_id = out_ff.id;
   assign rsp_ch.entry_port = out_ff.port;
   assign rsp_ch.entry_heartbeat = out_ff.heartbeat;
   assign rsp_ch.last = out_last_ff;

endmodule

/* rtl/gossip_membership_table_top.sv */
// Top level of the gossip membership table: CSR block, front queue and engine.
// Sequencing: merge scans the table entry by entry, then adds or replaces; tick scans and
// compacts, computes the ping modulo (one quotient bit a cycle) and probes for a ping; list scans.
// Throughput: one transaction at a time in the engine, set by the sequential table scan;
// the front queue holds two more. Reset is synchronous, active high: the table holds only
// this node, local heartbeat zero, registers at their reset values; no clearing pass.
module gossip_membership_table_top
   import gmt_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
)
(
   input  logic             clock,
   input  logic             reset,
   gmt_req_if.sink          req_ch,
   gmt_rsp_if.source        rsp_ch,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [AddrW-1:0] csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   cfg_type  cfg;
   logic     item_valid;
   item_type item;
   logic     item_pop;

   assign csr_pready = 1'b1;

   gmt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   gmt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .self_id    (cfg.self_id),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   gmt_engine #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

/* verif/testbench.sv */
// Testbench of the gossip membership table: directed table, random gossip traffic, scoreboard.
`timescale 1ns / 100ps

module testbench;
   import gmt_pkg::*;

   typedef struct packed {
      logic [KindW-1:0] kind;
      logic [IdW-1:0]   id;
      logic [PortW-1:0] port;
      logic [HbW-1:0]   heartbeat;
      logic             last;
   } member_result_type;

   typedef struct packed {
      logic [OpW-1:0]   op;
      logic [IdW-1:0]   id;
      logic [PortW-1:0] port;
      logic [HbW-1:0]   heartbeat;
      logic [3:0]       repeats;
      logic             typed;
      logic [KindW-1:0] kind;
      logic [IdW-1:0]   eid;
      logic [PortW-1:0] eport;
      logic [HbW-1:0]   ehb;
   } dir_row_type;

   localparam logic [OpW-1:0] OP_BAD = 2'd3;
   localparam int Depth = 32;
   localparam int SettleCycles = 300;

   localparam dir_row_type DirTab [14] = '{
      '{OP_LIST, 31'd0, 16'd0, 32'd0, 4'd1, 1'b1, K_LIVE, 31'd1, 16'd0, 32'd0},
      '{OP_TICK, 31'd0, 16'd0, 32'd0, 4'd1, 1'b1, K_ALONE, 31'd1, 16'd0, 32'd1},
      '{OP_MERGE, 31'd1, 16'd9, 32'd5, 4'd1, 1'b1, K_NONE, 31'd1, 16'd9, 32'd5},
      '{OP_BAD, 31'h7fffffff, 16'hffff, 32'hffffffff, 4'd1, 1'b1, K_NONE, 31'd0, 16'd0, 32'd0},
      '{OP_MERGE, 31'd5, 16'd7, 32'd10, 4'd1, 1'b1, K_ADDED, 31'd5, 16'd7, 32'd10},
      '{OP_MERGE, 31'd5, 16'd7, 32'd10, 4'd1, 1'b1, K_NONE, 31'd5, 16'd7, 32'd10},
      '{OP_MERGE, 31'd5, 16'd7, 32'd11, 4'd1, 1'b1, K_REFRESHED, 31'd5, 16'd7, 32'd11},
      '{OP_MERGE, 31'd5, 16'd8, 32'd3, 4'd1, 1'b1, K_ADDED, 31'd5, 16'd8, 32'd3},
      '{OP_MERGE, 31'h7fffffff, 16'hffff, 32'hffffffff, 4'd1, 1'b1, K_ADDED,
        31'h7fffffff, 16'hffff, 32'hffffffff},
      '{OP_MERGE, 31'd0, 16'd0, 32'd0, 4'd1, 1'b1, K_ADDED, 31'd0, 16'd0, 32'd0},
      '{OP_MERGE, 31'h7fffffff, 16'hffff, 32'd0, 4'd1, 1'b1, K_NONE,
        31'h7fffffff, 16'hffff, 32'hffffffff},
      '{OP_LIST, 31'd0, 16'd0, 32'd0, 4'd1, 1'b0, K_NONE, 31'd0, 16'd0, 32'd0},
      '{OP_TICK, 31'd0, 16'd0, 32'd0, 4'd7, 1'b0, K_NONE, 31'd0, 16'd0, 32'd0},
      '{OP_LIST, 31'd0, 16'd0, 32'd0, 4'd1, 1'b0, K_NONE, 31'd0, 16'd0, 32'd0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [AddrW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   gmt_req_if req_bus ();
   gmt_rsp_if rsp_bus ();

   gossip_membership_table_top u_top (
      .clock(clock), .reset(reset), .req_ch(req_bus), .rsp_ch(rsp_bus),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #2 clock = ~clock;

   // membership predictor state
   logic [IdW-1:0]   cfg_self_id;
   logic [PortW-1:0] cfg_self_port;
   logic [ToW-1:0]   cfg_fail_to, cfg_remove_to;
   logic [IdW-1:0]   tbl_id [Depth];
   logic [PortW-1:0] tbl_port [Depth];
   logic [HbW-1:0]   tbl_hb [Depth];
   logic [HbW-1:0]   tbl_stamp [Depth];
   int unsigned      tbl_count;
   logic [HbW-1:0]   local_hb;

   member_result_type pending_results[$];
   member_result_type step_out[$];
   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int kind_tally [8];
   bit idle_on = 1'b1;
   bit hold_req = 1'b0;

   task automatic report(input string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   function automatic logic [HbW-1:0] age_of(int i);
      return local_hb - tbl_stamp[i];
   endfunction

   function automatic void note(logic [KindW-1:0] k, logic [IdW-1:0] id, logic [PortW-1:0] port,
                                logic [HbW-1:0] hb);
      member_result_type r;
      r = '{k, id, port, hb, 1'b0};
      step_out = {step_out, r};
   endfunction

   function automatic void note_entry(logic [KindW-1:0] k, int i);
      note(k, tbl_id[i], tbl_port[i], tbl_hb[i]);
   endfunction

   function automatic void fold_gossip(logic [IdW-1:0] id, logic [PortW-1:0] port,
                                       logic [HbW-1:0] hb);
      int pos;
      logic [HbW-1:0] ts;
      if (id == cfg_self_id) begin
         note(K_NONE, id, port, hb);
         return;
      end
      for (int i = 0; i < tbl_count; i++) begin
         if (tbl_id[i] == id && tbl_port[i] == port) begin
            if (tbl_hb[i] < hb) begin
               tbl_hb[i] = hb;
               tbl_stamp[i] = local_hb;
               note_entry(K_REFRESHED, i);
            end else begin
               note_entry(K_NONE, i);
            end
            return;
         end
      end
      if (tbl_count < Depth) begin
         pos = tbl_count;
         tbl_count++;
         tbl_id[pos] = id; tbl_port[pos] = port; tbl_hb[pos] = hb; tbl_stamp[pos] = local_hb;
         note_entry(K_ADDED, pos);
         return;
      end
      pos = 1;
      ts = local_hb;
      for (int i = 1; i < tbl_count; i++) begin
         if (tbl_stamp[i] < ts) begin
            ts = tbl_stamp[i];
            pos = i;
         end
      end
      note_entry(K_REPLACED, pos);
      tbl_id[pos] = id; tbl_port[pos] = port; tbl_hb[pos] = hb; tbl_stamp[pos] = local_hb;
   endfunction

   function automatic void advance_tick();
      int w;
      longint unsigned span, offset, pos;
      local_hb = local_hb + 1;
      tbl_hb[0] = local_hb;
      tbl_stamp[0] = local_hb;
      w = 1;
      for (int r = 1; r < tbl_count; r++) begin
         if (age_of(r) >= {16'd0, cfg_remove_to}) begin
            note_entry(K_REMOVED, r);
         end else begin
            tbl_id[w] = tbl_id[r]; tbl_port[w] = tbl_port[r];
            tbl_hb[w] = tbl_hb[r]; tbl_stamp[w] = tbl_stamp[r];
            w++;
         end
      end
      tbl_count = w;
      if (tbl_count <= 1) begin
         note_entry(K_ALONE, 0);
         return;
      end
      span = tbl_count - 1;
      offset = 0;
      pos = ((longint'(local_hb) + offset) % span) + 1;
      while (offset < tbl_count && age_of(int'(pos)) > {16'd0, cfg_fail_to}) begin
         offset++;
         pos = ((longint'(local_hb) + offset) % span) + 1;
      end
      if (age_of(int'(pos)) < {16'd0, cfg_fail_to}) note_entry(K_PING, int'(pos));
      else note(K_NONE, '0, '0, '0);
   endfunction

   function automatic void predict_membership(logic [OpW-1:0] op, logic [IdW-1:0] id,
                                              logic [PortW-1:0] port, logic [HbW-1:0] hb);
      step_out.delete();
      case (op)
         OP_MERGE: fold_gossip(id, port, hb);
         OP_TICK: advance_tick();
         OP_LIST: begin
            for (int i = 0; i < tbl_count; i++)
               if (age_of(i) <= {16'd0, cfg_fail_to}) note_entry(K_LIVE, i);
         end
         default: note(K_NONE, '0, '0, '0);
      endcase
   endfunction

   function automatic void queue_results();
      if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
      pending_results = {pending_results, step_out};
   endfunction

   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_item(input logic [OpW-1:0] op, input logic [IdW-1:0] id,
                            input logic [PortW-1:0] port, input logic [HbW-1:0] hb,
                            input bit typed, input member_result_type want);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.member_id <= id;
      req_bus.member_port <= port;
      req_bus.member_heartbeat <= hb;
      do @(posedge clock); while (!req_bus.ready);
      predict_membership(op, id, port, hb);
      if (typed) begin
         step_out.delete();
         step_out = {step_out, want};
      end
      queue_results();
      items_sent++;
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   task automatic settle();
      while (pending_results.size() > 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] ridx, input logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {ridx, 2'b00}; csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (ridx)
         REG_SELF_ID: begin cfg_self_id = val[IdW-1:0]; tbl_id[0] = cfg_self_id; end
         REG_SELF_PORT: begin cfg_self_port = val[PortW-1:0]; tbl_port[0] = cfg_self_port; end
         REG_FAIL_TO: cfg_fail_to = val[ToW-1:0];
         default: cfg_remove_to = val[ToW-1:0];
      endcase
   endtask

   task automatic apply_settings(input logic [31:0] sid, input logic [31:0] sport,
                                 input logic [31:0] fto, input logic [31:0] rto);
      settle();
      csr_write(REG_SELF_ID, sid);
      csr_write(REG_SELF_PORT, sport);
      csr_write(REG_FAIL_TO, fto);
      csr_write(REG_REMOVE_TO, rto);
   endtask

   task automatic run_random(input int n, input int pool, input int hold_at);
      int r;
      logic [OpW-1:0] op;
      logic [IdW-1:0] id;
      logic [PortW-1:0] port;
      logic [HbW-1:0] hb;
      for (int k = 0; k < n; k++) begin
         if (k == hold_at) hold_req = 1'b1;
         r = $urandom_range(0, 99);
         op = (r < 45) ? OP_MERGE : (r < 75) ? OP_TICK : (r < 95) ? OP_LIST : OP_BAD;
         r = $urandom_range(0, 99);
         id = (r < 8) ? cfg_self_id : (r < 18) ? IdW'($urandom) : IdW'($urandom_range(0, pool));
         port = ($urandom_range(0, 9) < 8) ? PortW'(id * 7) : PortW'($urandom);
         hb = $urandom_range(0, 1) ? HbW'($urandom_range(0, 60)) : HbW'($urandom);
         send_item(op, id, port, hb, 1'b0, '0);
      end
      drop_valid();
   endtask

   // result sink: random stalls plus one long hold-off
   initial begin
      int stall_run;
      int hold_left;
      stall_run = 0;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_run > 0) begin
            stall_run--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if ($urandom_range(0, 5) == 0) stall_run = pick_gap();
            rsp_bus.ready <= (stall_run == 0);
         end
      end
   end

   always @(posedge clock) begin
      member_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         kind_tally[rsp_bus.result_kind]++;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result kind %0d id %0h", rsp_bus.result_kind,
                             rsp_bus.entry_id));
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.result_kind !== want.kind)
               report($sformatf("kind %0d, want %0d", rsp_bus.result_kind, want.kind));
            if (rsp_bus.entry_id !== want.id)
               report($sformatf("id %0h, want %0h", rsp_bus.entry_id, want.id));
            if (rsp_bus.entry_port !== want.port)
               report($sformatf("port %0h, want %0h", rsp_bus.entry_port, want.port));
            if (rsp_bus.entry_heartbeat !== want.heartbeat)
               report($sformatf("heartbeat %0h, want %0h", rsp_bus.entry_heartbeat,
                                want.heartbeat));
            if (rsp_bus.last !== want.last)
               report($sformatf("last %0b, want %0b", rsp_bus.last, want.last));
         end
      end
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      member_result_type want;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_MERGE;
      req_bus.member_id = '0;
      req_bus.member_port = '0;
      req_bus.member_heartbeat = '0;
      foreach (kind_tally[i]) kind_tally[i] = 0;
      cfg_self_id = 31'd1; cfg_self_port = '0; cfg_fail_to = 16'd5; cfg_remove_to = 16'd20;
      tbl_id[0] = 31'd1; tbl_port[0] = '0; tbl_hb[0] = '0; tbl_stamp[0] = '0;
      tbl_count = 1;
      local_hb = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DirTab[i]) begin
         want = '{DirTab[i].kind, DirTab[i].eid, DirTab[i].eport, DirTab[i].ehb, 1'b1};
         repeat (DirTab[i].repeats)
            send_item(DirTab[i].op, DirTab[i].id, DirTab[i].port, DirTab[i].heartbeat,
                      DirTab[i].typed, want);
      end
      drop_valid();

      run_random(100, 60, -1);
      idle_on = 1'b0;
      apply_settings(32'h7fffffff, 32'hffff, 32'hffff, 32'hffff);
      run_random(110, 90, -1);
      idle_on = 1'b1;
      apply_settings(32'd0, 32'd0, 32'd0, 32'd0);
      run_random(60, 20, -1);
      apply_settings(32'd9, 32'd3, 32'd3, 32'd8);
      run_random(130, 40, 20);
      apply_settings(32'h2a5, 32'h5a5a, 32'd12, 32'd40);
      run_random(60, 50, -1);

      settle();
      if (pending_results.size() > 0) report("results still outstanding at end");
      $display("Ran %0d transactions in, %0d results out, across five register settings",
               items_sent, results_seen);
      $display("Kinds: none %0d added %0d replaced %0d refreshed %0d removed %0d ping %0d",
               kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3], kind_tally[4],
               kind_tally[5]);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
